@@ rtl/core/tseg_pkg.sv @@
package tseg_pkg;

	localparam int LAT_W          = 28;
	localparam int IDX_OUT_W      = 16;
	localparam int EDGE_W         = 16;
	localparam int CFG_DATA_W     = 28;
	localparam int CFG_INDEX_W    = 2;
	localparam int MAX_POINTS_DEF = 65536;
	localparam int MAX_PUSH       = 3;
	localparam int PUSH_CNT_W     = 2;
	localparam int FIFO_DEPTH     = 8;

	localparam logic [1:0] ZONE_SOUTH = 2'd0;
	localparam logic [1:0] ZONE_MID   = 2'd1;
	localparam logic [1:0] ZONE_NORTH = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOUTH_LIMIT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NORTH_LIMIT   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_EDGE_SIZE = 2'd3;

	localparam logic signed [LAT_W-1:0] SOUTH_LIMIT_RST = -28'sd60000000;
	localparam logic signed [LAT_W-1:0] NORTH_LIMIT_RST = 28'sd60000000;

	typedef struct packed {
		logic signed [LAT_W-1:0] latitude;
		logic                    is_last_point;
	} in_word_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] seg_first;
		logic [IDX_OUT_W-1:0] seg_last;
		logic [1:0]           zone;
		logic                 is_last_segment;
	} out_word_t;

	typedef struct packed {
		logic                    mode;
		logic signed [LAT_W-1:0] lat_south;
		logic signed [LAT_W-1:0] lat_north;
		logic [EDGE_W-1:0]       edge_min;
	} cfg_t;

	typedef struct packed {
		logic [PUSH_CNT_W-1:0]          count;
		out_word_t [MAX_PUSH-1:0]       words;
	} push_t;

endpackage

@@ rtl/core/tseg_cfg.sv @@
module tseg_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tseg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tseg_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tseg_pkg::cfg_t                     cfg
);

	tseg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= 1'b0;
			cfg_q.lat_south <= tseg_pkg::SOUTH_LIMIT_RST;
			cfg_q.lat_north <= tseg_pkg::NORTH_LIMIT_RST;
			cfg_q.edge_min  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tseg_pkg::REG_MODE: begin
					cfg_q.mode <= cfg_data[0];
				end
				tseg_pkg::REG_SOUTH_LIMIT: begin
					cfg_q.lat_south <= $signed(cfg_data[tseg_pkg::LAT_W-1:0]);
				end
				tseg_pkg::REG_NORTH_LIMIT: begin
					cfg_q.lat_north <= $signed(cfg_data[tseg_pkg::LAT_W-1:0]);
				end
				tseg_pkg::REG_MIN_EDGE_SIZE: begin
					cfg_q.edge_min <= cfg_data[tseg_pkg::EDGE_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/tseg_step.sv @@
module tseg_step #(
	parameter int MAX_POINTS = tseg_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tseg_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  tseg_pkg::in_word_t  in_data,
	input  logic                room,
	output tseg_pkg::push_t     push
);

	localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = (CNT_W > tseg_pkg::EDGE_W) ? CNT_W : tseg_pkg::EDGE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_ASC  = 2'd1,
		DIR_DESC = 2'd2
	} dir_t;

	typedef struct packed {
		logic [IDX_W-1:0]      first;
		logic [IDX_W-1:0]      last;
		logic [1:0]            zone;
		logic [2:0][CNT_W-1:0] cnt;
		logic [1:0]            head_zone;
		logic                  head_shared;
	} span_t;

	function automatic logic [1:0] classify(input logic signed [tseg_pkg::LAT_W-1:0] lat,
			input tseg_pkg::cfg_t c);
		logic [1:0] zz;
		if (lat < $signed(c.lat_south)) begin
			zz = tseg_pkg::ZONE_SOUTH;
		end else if (lat > $signed(c.lat_north)) begin
			zz = tseg_pkg::ZONE_NORTH;
		end else begin
			zz = tseg_pkg::ZONE_MID;
		end
		return zz;
	endfunction

	function automatic logic [CMP_W-1:0] span_size(input span_t s);
		logic [CNT_W-1:0] sz;
		sz = {1'b0, s.last} - {1'b0, s.first} + CNT_W'(1);
		return CMP_W'(sz);
	endfunction

	function automatic span_t merge_spans(input span_t a, input span_t b);
		span_t r;
		r.first = a.first;
		r.last  = b.last;
		r.zone  = (span_size(a) >= span_size(b)) ? a.zone : b.zone;
		for (int k = 0; k < 3; k++) begin
			r.cnt[k] = a.cnt[k] + b.cnt[k];
		end
		// The shared reversal point was counted in both ranges; keep it once.
		if (b.head_shared && (r.cnt[b.head_zone] != '0)) begin
			r.cnt[b.head_zone] = r.cnt[b.head_zone] - CNT_W'(1);
		end
		r.head_zone   = a.head_zone;
		r.head_shared = a.head_shared;
		return r;
	endfunction

	function automatic tseg_pkg::out_word_t emit_word(input span_t s, input logic last_flag,
			input logic mode);
		tseg_pkg::out_word_t w;
		logic [IDX_W+tseg_pkg::IDX_OUT_W-1:0] first_ext;
		logic [IDX_W+tseg_pkg::IDX_OUT_W-1:0] last_ext;
		logic [1:0] zz;
		first_ext = {{tseg_pkg::IDX_OUT_W{1'b0}}, s.first};
		last_ext  = {{tseg_pkg::IDX_OUT_W{1'b0}}, s.last};
		zz = s.zone;
		if (mode) begin
			zz = tseg_pkg::ZONE_SOUTH;
			if (s.cnt[tseg_pkg::ZONE_MID] > s.cnt[zz]) begin
				zz = tseg_pkg::ZONE_MID;
			end
			if (s.cnt[tseg_pkg::ZONE_NORTH] > s.cnt[zz]) begin
				zz = tseg_pkg::ZONE_NORTH;
			end
		end
		w.seg_first       = first_ext[tseg_pkg::IDX_OUT_W-1:0];
		w.seg_last        = last_ext[tseg_pkg::IDX_OUT_W-1:0];
		w.zone            = zz;
		w.is_last_segment = last_flag;
		return w;
	endfunction

	// Input register.
	logic                              valid_s1;
	logic signed [tseg_pkg::LAT_W-1:0] lat_s1;
	logic                              last_s1;
	logic                              adv;

	// Track state.
	logic [IDX_W-1:0]                  idx_q;
	logic signed [tseg_pkg::LAT_W-1:0] prev_q;
	dir_t                              dir_q;
	span_t                             open_q;
	span_t                             held_q;
	logic [1:0]                        closed_q;
	logic                              first_small_q;

	// Next state.
	logic [IDX_W-1:0]                  idx_n;
	dir_t                              dir_n;
	span_t                             open_n;
	span_t                             held_n;
	logic [1:0]                        closed_n;
	logic                              first_small_n;

	logic [1:0]  z;
	logic [1:0]  pz;
	dir_t        nd;
	logic        split;
	logic        shared;
	logic        track_end;
	span_t       cur;
	span_t       fin;
	logic [CMP_W-1:0] min_edge;
	tseg_pkg::push_t  push_c;

	assign adv      = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign min_edge = CMP_W'(cfg.edge_min);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && (!valid_s1 || adv)) begin
			lat_s1  <= in_data.latitude;
			last_s1 <= in_data.is_last_point;
		end
	end

	always_comb begin
		idx_n         = idx_q + IDX_W'(1);
		dir_n         = dir_q;
		open_n        = open_q;
		held_n        = held_q;
		closed_n      = closed_q;
		first_small_n = first_small_q;
		push_c        = '0;
		z             = classify(lat_s1, cfg);
		pz            = classify(prev_q, cfg);
		nd            = DIR_NONE;
		split         = 1'b0;
		shared        = 1'b0;
		cur           = open_q;
		cur.last      = idx_q - IDX_W'(1);
		track_end     = last_s1 || (idx_q == LAST_IDX);

		if (idx_q == '0) begin
			open_n.first       = '0;
			open_n.cnt         = '0;
			open_n.zone        = z;
			open_n.head_zone   = z;
			open_n.head_shared = 1'b0;
			dir_n              = DIR_NONE;
		end else begin
			if (lat_s1 > prev_q) begin
				nd = DIR_ASC;
			end else if (lat_s1 < prev_q) begin
				nd = DIR_DESC;
			end
			if (!cfg.mode) begin
				split = (z != open_q.zone);
			end else if ((nd != DIR_NONE) && (dir_q != DIR_NONE) && (nd != dir_q)) begin
				split  = 1'b1;
				shared = 1'b1;
			end
			if (nd != DIR_NONE) begin
				dir_n = nd;
			end
			if (split) begin
				if (closed_q == 2'd0) begin
					held_n        = cur;
					first_small_n = span_size(cur) < min_edge;
					closed_n      = 2'd1;
				end else begin
					if ((closed_q == 2'd1) && first_small_q) begin
						held_n = merge_spans(held_q, cur);
					end else begin
						push_c.words[push_c.count] = emit_word(held_q, 1'b0, cfg.mode);
						push_c.count = push_c.count + 2'd1;
						held_n = cur;
					end
					closed_n = 2'd2;
				end
				open_n.cnt = '0;
				if (shared) begin
					// The reversal point opens the next range as well.
					open_n.first       = idx_q - IDX_W'(1);
					open_n.cnt[pz]     = CNT_W'(1);
					open_n.zone        = pz;
					open_n.head_zone   = pz;
					open_n.head_shared = 1'b1;
				end else begin
					open_n.first       = idx_q;
					open_n.zone        = z;
					open_n.head_zone   = z;
					open_n.head_shared = 1'b0;
				end
			end
		end
		open_n.cnt[z] = open_n.cnt[z] + CNT_W'(1);

		fin      = open_n;
		fin.last = idx_q;
		if (track_end) begin
			if (closed_n == 2'd0) begin
				push_c.words[push_c.count] = emit_word(fin, 1'b1, cfg.mode);
				push_c.count = push_c.count + 2'd1;
			end else if ((span_size(fin) < min_edge) ||
					((closed_n == 2'd1) && first_small_n)) begin
				push_c.words[push_c.count] = emit_word(merge_spans(held_n, fin), 1'b1, cfg.mode);
				push_c.count = push_c.count + 2'd1;
			end else begin
				push_c.words[push_c.count] = emit_word(held_n, 1'b0, cfg.mode);
				push_c.count = push_c.count + 2'd1;
				push_c.words[push_c.count] = emit_word(fin, 1'b1, cfg.mode);
				push_c.count = push_c.count + 2'd1;
			end
			idx_n         = '0;
			dir_n         = DIR_NONE;
			closed_n      = 2'd0;
			first_small_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			dir_q         <= DIR_NONE;
			closed_q      <= 2'd0;
			first_small_q <= 1'b0;
			prev_q        <= '0;
		end else if (adv) begin
			idx_q         <= idx_n;
			dir_q         <= dir_n;
			closed_q      <= closed_n;
			first_small_q <= first_small_n;
			prev_q        <= track_end ? '0 : lat_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			open_q <= open_n;
			held_q <= held_n;
		end
	end

	always_comb begin
		push       = push_c;
		push.count = adv ? push_c.count : 2'd0;
	end

endmodule

@@ rtl/core/tseg_fifo.sv @@
module tseg_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tseg_pkg::push_t      push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tseg_pkg::out_word_t  out_data
);

	localparam int PTR_W = $clog2(tseg_pkg::FIFO_DEPTH);
	localparam int FILL_W = PTR_W + 1;
	localparam logic [FILL_W-1:0] ROOM_MAX = FILL_W'(tseg_pkg::FIFO_DEPTH - tseg_pkg::MAX_PUSH);

	tseg_pkg::out_word_t mem_q [tseg_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [FILL_W-1:0]   fill_q;
	logic                pop;

	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && !out_stall;
	// Room for a full burst of words, whatever the consumer does this cycle.
	assign room      = (fill_q <= ROOM_MAX);
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		for (int k = 0; k < tseg_pkg::MAX_PUSH; k++) begin
			if (k < int'(push.count)) begin
				mem_q[wr_q + PTR_W'(k)] <= push.words[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + PTR_W'(push.count);
			rd_q   <= rd_q + PTR_W'(pop);
			fill_q <= fill_q + FILL_W'(push.count) - FILL_W'(pop);
		end
	end

endmodule

@@ rtl/core/track_segmenter_edge_merge.sv @@
// Flow: a word is accepted into the input register; its result words enter the output
// queue from that register when the queue has room, and leave it in order.
// Throughput: one input word per cycle while the eight-entry output queue has room for
// three words; results leave one per cycle while out_stall is low, bounding the input.
// Reset: arst_n clears the track state, the queue and the registers to their defaults.
module track_segmenter_edge_merge #(
	parameter int MAX_POINTS = tseg_pkg::MAX_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tseg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tseg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tseg_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tseg_pkg::out_word_t              out_data
);

	tseg_pkg::cfg_t  cfg;
	tseg_pkg::push_t push;
	logic            room;

	tseg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tseg_step #(
		.MAX_POINTS (MAX_POINTS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.room     (room),
		.push     (push)
	);

	tseg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ verif/track_segmenter_edge_merge_tb.sv @@
module track_segmenter_edge_merge_tb;
	import tseg_pkg::*;

	localparam logic MODE_ZONE = 1'b0;
	localparam logic MODE_TURN = 1'b1;
	localparam int LAT_MAX = 90000000;
	localparam int unsigned TRACK_MAX = MAX_POINTS_DEF;
	localparam int RANDOM_ITEMS = 445;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [1:0] {HEAD_NONE, HEAD_UP, HEAD_DOWN} heading_t;

	typedef struct packed {
		int unsigned      first;
		int unsigned      last;
		logic [1:0]       zone;
		logic [2:0][16:0] cnt;
		logic [1:0]       lead_zone;
		logic             lead_shared;
	} range_t;

	class segment_scoreboard;
		logic mode;
		logic signed [LAT_W-1:0] south;
		logic signed [LAT_W-1:0] north;
		logic [EDGE_W-1:0] min_edge;

		int unsigned pt_index;
		logic signed [LAT_W-1:0] prev_lat;
		heading_t heading;
		range_t open_r;
		range_t held_r;
		logic [1:0] closed;
		bit first_tiny;

		out_word_t expected_segments[$];
		int errors;

		function new();
			mode = MODE_ZONE;
			south = SOUTH_LIMIT_RST;
			north = NORTH_LIMIT_RST;
			min_edge = '0;
			errors = 0;
			clear_track();
		endfunction

		function void clear_track();
			pt_index = 0;
			prev_lat = '0;
			heading = HEAD_NONE;
			open_r = '0;
			open_r.zone = ZONE_MID;
			open_r.lead_zone = ZONE_MID;
			closed = 2'd0;
			first_tiny = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MODE:          mode = data[0];
				REG_SOUTH_LIMIT:   south = data;
				REG_NORTH_LIMIT:   north = data;
				REG_MIN_EDGE_SIZE: min_edge = data[EDGE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [1:0] zone_of(logic signed [LAT_W-1:0] lat);
			if (lat < south) return ZONE_SOUTH;
			if (lat > north) return ZONE_NORTH;
			return ZONE_MID;
		endfunction

		function int unsigned span_len(range_t r);
			return r.last - r.first + 1;
		endfunction

		// The head point of a range that starts on a reversal is also the tail of the
		// range before it, so it is counted once when the two are merged.
		function range_t merge_ranges(range_t a, range_t b);
			range_t r;
			r = a;
			r.last = b.last;
			r.zone = (span_len(a) >= span_len(b)) ? a.zone : b.zone;
			for (int z = 0; z < 3; z++) r.cnt[z] = a.cnt[z] + b.cnt[z];
			if (b.lead_shared && r.cnt[b.lead_zone] != 0)
				r.cnt[b.lead_zone] = r.cnt[b.lead_zone] - 17'd1;
			return r;
		endfunction

		function void push_segment(range_t r, logic is_end);
			out_word_t w;
			logic [1:0] z;
			z = r.zone;
			if (mode == MODE_TURN) begin
				z = ZONE_SOUTH;
				if (r.cnt[ZONE_MID] > r.cnt[z]) z = ZONE_MID;
				if (r.cnt[ZONE_NORTH] > r.cnt[z]) z = ZONE_NORTH;
			end
			w.seg_first = r.first[IDX_OUT_W-1:0];
			w.seg_last = r.last[IDX_OUT_W-1:0];
			w.zone = z;
			w.is_last_segment = is_end;
			expected_segments = {expected_segments, w};
		endfunction

		function void note_point(in_word_t w);
			logic signed [LAT_W-1:0] lat;
			logic [1:0] z;
			logic [1:0] pz;
			bit fin;
			bit split;
			bit shared;
			bit tiny;
			heading_t nd;
			int unsigned idx;
			range_t cur;
			lat = w.latitude;
			fin = w.is_last_point;
			idx = pt_index;
			z = zone_of(lat);
			if (idx >= TRACK_MAX - 1) fin = 1'b1;

			if (idx == 0) begin
				open_r.first = 0;
				open_r.cnt = '0;
				open_r.zone = z;
				open_r.lead_zone = z;
				open_r.lead_shared = 1'b0;
				heading = HEAD_NONE;
			end else begin
				split = 1'b0;
				shared = 1'b0;
				nd = HEAD_NONE;
				if (lat > prev_lat) nd = HEAD_UP;
				else if (lat < prev_lat) nd = HEAD_DOWN;
				if (mode == MODE_ZONE) begin
					split = (z != open_r.zone);
				end else if (nd != HEAD_NONE && heading != HEAD_NONE && nd != heading) begin
					split = 1'b1;
					shared = 1'b1;
				end
				if (nd != HEAD_NONE) heading = nd;
				if (split) begin
					cur = open_r;
					cur.last = idx - 1;
					tiny = span_len(cur) < min_edge;
					if (closed == 2'd0) begin
						held_r = cur;
						first_tiny = tiny;
						closed = 2'd1;
					end else begin
						if (closed == 2'd1 && first_tiny) begin
							held_r = merge_ranges(held_r, cur);
						end else begin
							push_segment(held_r, 1'b0);
							held_r = cur;
						end
						closed = 2'd2;
					end
					open_r.cnt = '0;
					if (shared) begin
						pz = zone_of(prev_lat);
						open_r.first = idx - 1;
						open_r.cnt[pz] = 17'd1;
						open_r.zone = pz;
						open_r.lead_zone = pz;
						open_r.lead_shared = 1'b1;
					end else begin
						open_r.first = idx;
						open_r.zone = z;
						open_r.lead_zone = z;
						open_r.lead_shared = 1'b0;
					end
				end
			end
			open_r.cnt[z] = open_r.cnt[z] + 17'd1;
			prev_lat = lat;
			pt_index = idx + 1;

			if (fin) begin
				cur = open_r;
				cur.last = idx;
				if (closed == 2'd0) begin
					push_segment(cur, 1'b1);
				end else if (span_len(cur) < min_edge || (closed == 2'd1 && first_tiny)) begin
					push_segment(merge_ranges(held_r, cur), 1'b1);
				end else begin
					push_segment(held_r, 1'b0);
					push_segment(cur, 1'b1);
				end
				clear_track();
			end
		endfunction

		function void check_segment(out_word_t got);
			out_word_t want;
			if (expected_segments.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected segment: first %0d last %0d zone %0d end %0b",
						got.seg_first, got.seg_last, got.zone, got.is_last_segment);
				return;
			end
			want = expected_segments.pop_front();
			if (got.seg_first !== want.seg_first || got.seg_last !== want.seg_last ||
				got.zone !== want.zone || got.is_last_segment !== want.is_last_segment) begin
				errors++;
				if (errors <= 10)
					$display("segment mismatch: expected first %0d last %0d zone %0d end %0b, %s",
						want.seg_first, want.seg_last, want.zone, want.is_last_segment,
						$sformatf("got first %0d last %0d zone %0d end %0b",
							got.seg_first, got.seg_last, got.zone, got.is_last_segment));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;

	segment_scoreboard sb = new();
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit hold_req = 1'b0;
	int sent = 0;

	track_segmenter_edge_merge u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [LAT_W-1:0] any_lat();
		int v;
		v = int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
		return v[LAT_W-1:0];
	endfunction

	function automatic logic signed [LAT_W-1:0] pick_limit();
		case ($urandom_range(4))
			0: return -28'sd90000000;
			1: return 28'sd90000000;
			default: return any_lat();
		endcase
	endfunction

	task automatic send_point(logic signed [LAT_W-1:0] lat, logic is_end);
		in_word_t w;
		int gap;
		w.latitude = lat;
		w.is_last_point = is_end;
		gap = tx_idle ? $urandom_range(16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_point(w);
	endtask

	// Let every expected segment come out and the pipeline settle before a register write.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_segments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic set_regs(logic m, logic signed [LAT_W-1:0] s, logic signed [LAT_W-1:0] n,
		logic [EDGE_W-1:0] e);
		drain();
		write_cfg(REG_MODE, {27'd0, m});
		write_cfg(REG_SOUTH_LIMIT, s);
		write_cfg(REG_NORTH_LIMIT, n);
		write_cfg(REG_MIN_EDGE_SIZE, {12'd0, e});
	endtask

	task automatic random_setup();
		logic signed [LAT_W-1:0] s;
		logic signed [LAT_W-1:0] n;
		logic signed [LAT_W-1:0] t;
		logic [EDGE_W-1:0] e;
		s = pick_limit();
		n = pick_limit();
		// Mostly ordered limits; now and then leave them crossed.
		if ($urandom_range(4) != 0 && s > n) begin
			t = s;
			s = n;
			n = t;
		end
		case ($urandom_range(7))
			0: e = '0;
			1: e = 16'hFFFF;
			2: e = 16'($urandom);
			default: e = 16'($urandom_range(6, 1));
		endcase
		set_regs(1'($urandom_range(1)), s, n, e);
	endtask

	// A track is mostly a random walk so that direction runs and zone crossings occur,
	// with occasional jumps; a walk off leaves pure noise.
	task automatic run_track(int len, bit closed_track, bit walk);
		int lat;
		int step;
		bit up;
		lat = int'(any_lat());
		up = 1'($urandom_range(1));
		for (int i = 0; i < len; i++) begin
			if (!walk || $urandom_range(19) == 0) begin
				lat = int'(any_lat());
			end else if (i > 0) begin
				if ($urandom_range(4) == 0) up = !up;
				step = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(4000000));
				lat = up ? lat + step : lat - step;
				if (lat > LAT_MAX) lat = LAT_MAX;
				if (lat < -LAT_MAX) lat = -LAT_MAX;
			end
			send_point(lat[LAT_W-1:0], closed_track && i == len - 1);
			sent++;
		end
	endtask

	initial begin
		int n;
		forever begin
			n = hold_req ? HOLD_CYCLES : (rx_idle ? int'($urandom_range(16)) : 0);
			hold_req = 1'b0;
			@(negedge clk);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_segment(out_data);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("track_segmenter_edge_merge regression: fail");
		$finish;
	end

	initial begin
		int phase;
		int target;
		int len;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, no merging: a one-point track and zone boundaries at their edges.
		send_point(-28'sd90000000, 1'b1);
		send_point(28'sd90000000, 1'b0);
		send_point(28'sd60000000, 1'b0);
		send_point(-28'sd60000000, 1'b0);
		send_point(-28'sd60000001, 1'b0);
		send_point(28'sd60000001, 1'b1);

		// Small first and last ranges fold into their neighbors.
		set_regs(MODE_ZONE, SOUTH_LIMIT_RST, NORTH_LIMIT_RST, 16'd3);
		send_point(28'sd70000000, 1'b0);
		repeat (4) send_point(28'sd0, 1'b0);
		send_point(-28'sd70000000, 1'b1);

		// Reversals with flat steps, the turning point shared by both ranges.
		set_regs(MODE_TURN, -28'sd10, 28'sd10, 16'd2);
		send_point(28'sd0, 1'b0);
		send_point(28'sd0, 1'b0);
		send_point(28'sd20, 1'b0);
		send_point(28'sd15, 1'b0);
		send_point(28'sd15, 1'b0);
		send_point(-28'sd30, 1'b0);
		send_point(28'sd40, 1'b0);
		send_point(28'sd50, 1'b1);

		// Crossed limits, then new settings while the track is still open.
		set_regs(MODE_ZONE, 28'sd1000, -28'sd1000, 16'd0);
		send_point(-28'sd5000, 1'b0);
		send_point(28'sd500, 1'b0);
		send_point(28'sd5000, 1'b0);
		set_regs(MODE_TURN, -28'sd90000000, 28'sd90000000, 16'hFFFF);
		send_point(28'sd4000, 1'b0);
		send_point(28'sd3000, 1'b1);

		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			random_setup();
			tx_idle = $urandom_range(3) != 0;
			rx_idle = $urandom_range(3) != 0;
			if (phase == 2) begin
				tx_idle = 1'b0;
				hold_req = 1'b1;
			end
			target = sent + int'($urandom_range(70, 30));
			while (sent < target) begin
				len = ($urandom_range(5) == 0) ? int'($urandom_range(40, 13))
					: int'($urandom_range(12, 1));
				run_track(len, !(sent + len >= target && $urandom_range(3) == 0),
					phase != 2 && $urandom_range(4) != 0);
			end
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_segments.size() == 0)
			$display("track_segmenter_edge_merge regression: pass");
		else
			$display("track_segmenter_edge_merge regression: fail");
		$finish;
	end

endmodule
